// File: hdl/tdc_pkg.sv
// Shared types and constants for the TTL duplicate-packet cache.
// Used by tdc_cmp and ttl_dedup_cache; no other dependencies.
package tdc_pkg;

  localparam int ID_W    = 64;
  localparam int TIME_W  = 32;
  localparam int TTL_W   = 16;
  localparam int MODE_W  = 2;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHECK = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_PRUNE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // One table slot as it sits in the entry RAM.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] stamp;
    logic [ID_W-1:0]   id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of comparing one slot against the item in flight.
  typedef struct packed {
    logic expired;
    logic match;
    logic older;
  } cmp_t;

endpackage

// File: hdl/ttl_dedup_cache.sv
// Top level of the TTL duplicate-packet cache: sequencer, entry RAM and result register.
// Depends on tdc_pkg, tdc_ram and tdc_cmp.
//
// Usage. Each input beat on the s_ channel carries an operation in s_tuser and a
// packet ID plus the current time in seconds in s_tdata. Check reports in the
// result beat whether a live copy of the ID is in the table, dropping expired
// slots it walks past. Add stores the ID in the first free or expired slot, or
// else evicts the slot with the smallest stamp. Prune drops every expired slot.
// Every input beat yields exactly one result beat on the m_ channel; seen is 0
// for everything but a check hit.
// Timing. One slot is read from the entry RAM per cycle and handed to the single
// compare unit, so the walk covers the slots in order, and an eviction adds a
// write in the evict state; the walk ends early when a check hits or an add
// finds a free or expired slot. The unused operation code skips the walk.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so a stalled receiver does not block the next accept; the
// following result waits until the previous one has been taken.
// Reset. After rst the block runs a clearing pass that marks every slot invalid,
// with s_tready low. The TTL register resets to 30 and can be
// written through the cfg channel at any time the block is idle.
module ttl_dedup_cache
  import tdc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration: TTL in seconds.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TTL_W-1:0] cfg_data,
  // Input stream.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [63:0] pkt_ident, [95:64] now_sec
  input  logic [MODE_W-1:0] s_tuser,  // [1:0] mode
  // Result stream.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [0] seen, [7:1] zero
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENT_CNT  = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EVICT,
    ST_FINISH
  } state_t;

  state_t            state;
  mode_t             mode_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] now_r;
  logic [TTL_W-1:0]  ttl;

  // rd_cnt is the next slot to read (and the slot being cleared during reset).
  logic [CNT_W-1:0]  rd_cnt;
  // pv marks that RAM read data for slot proc_idx is present this cycle.
  logic              pv;
  logic [IDX_W-1:0]  proc_idx;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] best_t;
  logic              seen;
  logic              out_seen;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  entry_t            ent;
  entry_t            fresh;
  logic [ENTRY_W-1:0] rdata;
  cmp_t              flags;

  assign ent       = entry_t'(rdata);
  assign fresh     = '{valid: 1'b1, stamp: now_r, id: id_r};
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tdata   = {{(OUT_W - 1){1'b0}}, out_seen};

  tdc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  tdc_cmp u_cmp (
    .ent    (ent),
    .now    (now_r),
    .ttl    (ttl),
    .id     (id_r),
    .best_t (best_t),
    .flags  (flags)
  );

  // Write port: clearing pass, invalidation or insertion of the slot just read,
  // and the eviction write after a full walk.
  always_comb begin
    we    = 1'b0;
    waddr = proc_idx;
    wdata = ent;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = rd_cnt[IDX_W-1:0];
        wdata = '0;
      end
      ST_WALK: begin
        if (pv) begin
          case (mode_r)
            MODE_ADD: begin
              if (!ent.valid || flags.expired) begin
                we    = 1'b1;
                wdata = fresh;
              end
            end
            MODE_CHECK, MODE_PRUNE: begin
              if (ent.valid && flags.expired) begin
                we          = 1'b1;
                wdata.valid = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EVICT: begin
        we    = 1'b1;
        waddr = best_idx;
        wdata = fresh;
      end
      ST_IDLE, ST_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      rd_cnt   <= '0;
      pv       <= 1'b0;
      m_tvalid <= 1'b0;
      ttl      <= TTL_W'(30);
      seen     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ttl <= cfg_data;
      end
      // The finish state decides m_tvalid itself when it hands over a result.
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          if (rd_cnt == LAST_CNT) begin
            rd_cnt <= '0;
            state  <= ST_IDLE;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            mode_r <= mode_t'(s_tuser);
            id_r   <= s_tdata[ID_W-1:0];
            now_r  <= s_tdata[ID_W +: TIME_W];
            seen   <= 1'b0;
            rd_cnt <= '0;
            pv     <= 1'b0;
            state  <= (mode_t'(s_tuser) == MODE_NONE) ? ST_FINISH : ST_WALK;
          end
        end

        ST_WALK: begin
          if (rd_cnt != ENT_CNT) begin
            rd_cnt   <= rd_cnt + 1'b1;
            pv       <= 1'b1;
            proc_idx <= rd_cnt[IDX_W-1:0];
          end else begin
            pv <= 1'b0;
          end

          if (pv) begin
            case (mode_r)
              MODE_CHECK: begin
                // The walk stops at the first live match.
                if (ent.valid && !flags.expired && flags.match) begin
                  seen  <= 1'b1;
                  state <= ST_FINISH;
                end
              end
              MODE_ADD: begin
                if (!ent.valid || flags.expired) begin
                  state <= ST_FINISH;
                end else if (proc_idx == '0 || flags.older) begin
                  best_idx <= proc_idx;
                  best_t   <= ent.stamp;
                end
              end
              default: ;
            endcase
          end else if (rd_cnt == ENT_CNT) begin
            // Every slot has been processed.
            state <= (mode_r == MODE_ADD) ? ST_EVICT : ST_FINISH;
          end
        end

        ST_EVICT: begin
          state <= ST_FINISH;
        end

        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_seen <= seen;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // An accepted beat keeps the block busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  // The table is never written while the sequencer waits for work.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !we)
    else $error("entry RAM written while idle");

  // The clearing pass neither accepts items nor produces results.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s_tready && !m_tvalid))
    else $error("activity during clearing pass");

  // A result only appears at the end of an operation.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside of finish");

endmodule

// File: hdl/tdc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tdc_cmp.sv
// Shared compare unit: expiry test, ID match and eviction age compare for one slot.
// Depends on tdc_pkg.
module tdc_cmp
  import tdc_pkg::*;
(
  input  entry_t            ent,
  input  logic [TIME_W-1:0] now,
  input  logic [TTL_W-1:0]  ttl,
  input  logic [ID_W-1:0]   id,
  input  logic [TIME_W-1:0] best_t,
  output cmp_t              flags
);

  logic [TIME_W-1:0] age;

  // A negative age (slot stamped in the future) never counts as expired.
  assign age           = now - ent.stamp;
  assign flags.expired = !age[TIME_W-1] && (age > {{(TIME_W - TTL_W){1'b0}}, ttl});
  assign flags.match   = (ent.id == id);
  assign flags.older   = (ent.stamp < best_t);

endmodule
